/* sv/tsbc_pkg.sv */
// ----------------------------------------------------------------------------
// Toy block cipher package
// Shared sizes, types, register indexes and the round helper functions.
// ----------------------------------------------------------------------------
package tsbc_pkg;

    localparam int BLOCK_BYTES = 8;
    localparam int KEY_BYTES   = 8;
    localparam int MAX_ROUNDS  = 16;
    localparam int MIN_ROUNDS  = 4;

    localparam int BLOCK_W = 64;
    localparam int KEY_W   = 64;
    localparam int MAP_W   = 24;
    localparam int RND_W   = $clog2(MAX_ROUNDS + 1);
    localparam int CFG_W   = 64;

    typedef logic [BLOCK_W-1:0] t_block;
    typedef logic [KEY_W-1:0]   t_key;
    typedef logic [MAP_W-1:0]   t_map;
    typedef logic [RND_W-1:0]   t_rnd;
    typedef logic [1:0]         t_cfg_idx;
    typedef logic [CFG_W-1:0]   t_cfg_data;

    localparam t_cfg_idx CFG_KEY    = 2'd0;
    localparam t_cfg_idx CFG_PERM   = 2'd1;
    localparam t_cfg_idx CFG_ROUNDS = 2'd2;

    localparam logic CMD_ENCRYPT = 1'b0;
    localparam logic CMD_DECRYPT = 1'b1;

    localparam t_map PERM_RESET   = 24'hFAC688;
    localparam t_rnd ROUNDS_RESET = t_rnd'(MIN_ROUNDS);

    localparam t_block BLK_MASK = t_block'((65'd1 << (8 * BLOCK_BYTES)) - 65'd1);

    typedef struct packed {
        t_key key;
        t_map perm;
        t_rnd rounds;
    } t_cfg;

    typedef struct packed {
        logic   cmd;
        t_block data;
    } t_stage;

    function automatic t_block round_key(t_key key, t_rnd r);
        t_block k;
        int     idx;
        k = '0;
        for (int j = 0; j < BLOCK_BYTES; j++) begin
            idx = (j + 3 * int'(r) + 1) % KEY_BYTES;
            k[8*j +: 8] = key[8*idx +: 8];
        end
        return k;
    endfunction

    function automatic t_block perm_fwd(t_block s, t_map mp);
        t_block     o;
        logic [7:0] acc;
        logic [2:0] d;
        o = '0;
        for (int dd = 0; dd < BLOCK_BYTES; dd++) begin
            acc = '0;
            for (int i = 0; i < BLOCK_BYTES; i++) begin
                d = mp[3*i +: 3];
                if (int'(d) == dd) begin
                    acc = acc + s[8*i +: 8];
                end
            end
            o[8*dd +: 8] = acc;
        end
        return o;
    endfunction

    function automatic t_block perm_inv(t_block s, t_map mp);
        t_block     o;
        logic [2:0] src;
        o = '0;
        for (int i = 0; i < BLOCK_BYTES; i++) begin
            src = mp[3*i +: 3];
            if (int'(src) < BLOCK_BYTES) begin
                o[8*i +: 8] = s[8*src +: 8];
            end
        end
        return o;
    endfunction

endpackage

/* sv/tsbc_req_if.sv */
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying the direction and the block to be processed.
// ----------------------------------------------------------------------------
interface tsbc_req_if;
    import tsbc_pkg::*;

    logic   valid;
    logic   ready;
    logic   cmd;
    t_block block_in;

    modport source (output valid, output cmd, output block_in, input ready);
    modport sink   (input valid, input cmd, input block_in, output ready);
endinterface

/* sv/tsbc_rsp_if.sv */
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying the processed block.
// ----------------------------------------------------------------------------
interface tsbc_rsp_if;
    import tsbc_pkg::*;

    logic   valid;
    logic   ready;
    t_block block_out;

    modport source (output valid, output block_out, input ready);
    modport sink   (input valid, input block_out, output ready);
endinterface

/* sv/tsbc_round_cell.sv */
// ----------------------------------------------------------------------------
// Round cell
// One elastic stage of the round chain; applies the step assigned to its slot.
// ----------------------------------------------------------------------------
module tsbc_round_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  tsbc_pkg::t_cfg   i_cfg,
    input  tsbc_pkg::t_rnd   i_idx,
    input  logic            i_valid,
    output logic            o_ready,
    input  tsbc_pkg::t_stage i_stage,
    output logic            o_valid,
    input  logic            i_ready,
    output tsbc_pkg::t_stage o_stage
);
    import tsbc_pkg::*;

    logic   r_valid;
    t_stage r_stage;
    t_stage n_stage;
    t_rnd   nr_m1;
    t_block s;

    always_comb begin
        nr_m1   = i_cfg.rounds - 1'b1;
        s       = i_stage.data;
        n_stage = i_stage;
        if (i_stage.cmd == CMD_ENCRYPT) begin
            if (i_idx < nr_m1) begin
                n_stage.data = perm_fwd(~(s ^ round_key(i_cfg.key, i_idx)) & BLK_MASK,
                                        i_cfg.perm);
            end else if (i_idx == nr_m1) begin
                n_stage.data = (~(s ^ round_key(i_cfg.key, i_idx)) & BLK_MASK)
                               ^ round_key(i_cfg.key, i_idx + 1'b1);
            end
        end else begin
            if (i_idx == '0) begin
                n_stage.data = (~(s ^ round_key(i_cfg.key, i_cfg.rounds)) & BLK_MASK)
                               ^ round_key(i_cfg.key, nr_m1);
            end else if (i_idx < i_cfg.rounds) begin
                n_stage.data = (~perm_inv(s, i_cfg.perm) & BLK_MASK)
                               ^ round_key(i_cfg.key, nr_m1 - i_idx);
            end
        end
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_stage = r_stage;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_stage <= n_stage;
        end
    end

endmodule

/* sv/toy_spn_block_cipher_core.sv */
// ----------------------------------------------------------------------------
// Toy block cipher core
// Enciphers or deciphers 8-byte blocks through a chain of round cells.
// ----------------------------------------------------------------------------
// Usage:
// A transaction on the request channel carries a block and a direction
// (encrypt or decrypt); each one yields exactly one transaction on the
// response channel, in order. The key, the byte permutation and the round
// count are written through the configuration port by the user, only while
// no block is in flight (the block does not enforce this); a round count
// below four is stored as four. The chain has MAX_ROUNDS (16) cells, one
// register stage each, and every block passes all of them whatever the round
// count; one block is accepted in every cycle unless the chain is full and stalled.
// Each cell holds its block while the cell after it is occupied and stalled,
// so a stalled receiver fills the chain from its end; the request channel
// stays ready while any cell can still move.
// Reset empties the chain and restores the default configuration: a zero
// key, the identity permutation and four rounds.
// ----------------------------------------------------------------------------
module toy_spn_block_cipher_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    tsbc_req_if.sink            i_req,
    tsbc_rsp_if.source          o_rsp,
    input  logic                i_cfg_we,
    input  tsbc_pkg::t_cfg_idx  i_cfg_idx,
    input  tsbc_pkg::t_cfg_data i_cfg_wdata
);
    import tsbc_pkg::*;

    t_cfg       r_cfg;
    t_cfg       n_cfg;
    logic [4:0] wr_rounds;

    logic   chain_valid [MAX_ROUNDS+1];
    logic   chain_ready [MAX_ROUNDS+1];
    t_stage chain_stage [MAX_ROUNDS+1];

    always_comb begin
        n_cfg     = r_cfg;
        wr_rounds = i_cfg_wdata[4:0];
        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_KEY: begin
                    n_cfg.key = i_cfg_wdata[KEY_W-1:0];
                end
                CFG_PERM: begin
                    n_cfg.perm = i_cfg_wdata[MAP_W-1:0];
                end
                CFG_ROUNDS: begin
                    if (int'(wr_rounds) < MIN_ROUNDS) begin
                        n_cfg.rounds = t_rnd'(MIN_ROUNDS);
                    end else if (int'(wr_rounds) > MAX_ROUNDS) begin
                        n_cfg.rounds = t_rnd'(MAX_ROUNDS);
                    end else begin
                        n_cfg.rounds = t_rnd'(wr_rounds);
                    end
                end
                default: begin
                    n_cfg = r_cfg;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.key    <= '0;
            r_cfg.perm   <= PERM_RESET;
            r_cfg.rounds <= ROUNDS_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign chain_valid[0]      = i_req.valid;
    assign chain_stage[0].cmd  = i_req.cmd;
    assign chain_stage[0].data = i_req.block_in & BLK_MASK;
    assign i_req.ready         = chain_ready[0];

    for (genvar k = 0; k < MAX_ROUNDS; k++) begin : g_cell
        tsbc_round_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cfg   (r_cfg),
            .i_idx   (t_rnd'(k)),
            .i_valid (chain_valid[k]),
            .o_ready (chain_ready[k]),
            .i_stage (chain_stage[k]),
            .o_valid (chain_valid[k+1]),
            .i_ready (chain_ready[k+1]),
            .o_stage (chain_stage[k+1])
        );
    end

    assign chain_ready[MAX_ROUNDS] = o_rsp.ready;
    assign o_rsp.valid             = chain_valid[MAX_ROUNDS];
    assign o_rsp.block_out         = chain_stage[MAX_ROUNDS].data & BLK_MASK;

endmodule

/* sv/tsbc_checker.sv */
// ----------------------------------------------------------------------------
// Toy block cipher checker
// Port-level checks on the core, attached to every instance of it.
// ----------------------------------------------------------------------------
module tsbc_checker (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_in_valid,
    input logic            i_in_ready,
    input logic            i_out_valid,
    input logic            i_out_ready,
    input tsbc_pkg::t_block i_out_block
);
    import tsbc_pkg::*;

    // A reset cycle leaves no result on the response channel.
    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("response valid after reset");

    // When the last cell can move, every cell can, so requests are taken.
    a_ready_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_out_valid || i_out_ready) |-> i_in_ready)
        else $error("request not ready although the chain can advance");

    a_out_valid_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("response withdrawn while stalled");

    a_out_data_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> $stable(i_out_block))
        else $error("response block changed while stalled");

endmodule

bind toy_spn_block_cipher_core tsbc_checker u_tsbc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_req.valid),
    .i_in_ready  (i_req.ready),
    .i_out_valid (o_rsp.valid),
    .i_out_ready (o_rsp.ready),
    .i_out_block (o_rsp.block_out)
);
